@@ hdl/rfm_pkg.sv @@
// ----------------------------------------------------------------------------
// rfm_pkg - radio failsafe monitor types and constants
// Shared word, state and configuration types, register indices and event codes.
// ----------------------------------------------------------------------------
package rfm_pkg;

    localparam int unsigned NUM_CFG_REGS = 5;
    localparam int unsigned CFG_IDX_W    = 3;
    localparam int unsigned CFG_DATA_W   = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_FS_ENABLE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOW_PWM     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RADIO_TO    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_OVERRIDE_TO = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ZERO_DB     = 3'd4;

    localparam logic        RST_FS_ENABLE   = 1'b1;
    localparam logic [11:0] RST_LOW_PWM     = 12'd975;
    localparam logic [15:0] RST_RADIO_TO    = 16'd500;
    localparam logic [15:0] RST_OVERRIDE_TO = 16'd2000;
    localparam logic [15:0] RST_ZERO_DB     = 16'd400;

    localparam logic [1:0]  LOW_COUNT_MAX   = 2'd3;

    typedef enum logic [1:0] {
        EV_NONE     = 2'd0,
        EV_LOW_THR  = 2'd1,
        EV_TIMEOUT  = 2'd2,
        EV_CLEARED  = 2'd3
    } rfm_event_t;

    typedef struct packed {
        logic        fs_enable;
        logic [11:0] low_pwm;
        logic [15:0] radio_to;
        logic [15:0] override_to;
        logic [15:0] zero_db;
    } rfm_cfg_t;

    typedef struct packed {
        logic [31:0]        now_ms;
        logic               frame_present;
        logic [11:0]        thr_pulse;
        logic signed [15:0] throttle_ctrl;
        logic               overrides_active;
        logic               motors_armed;
    } rfm_item_t;

    typedef struct packed {
        logic        failsafe;
        logic [1:0]  low_count;
        logic        receiver;
        logic [31:0] last_frame_ms;
        logic [31:0] last_nonzero_ms;
        logic        zero;
    } rfm_state_t;

    typedef struct packed {
        logic       radio_failsafe;
        logic       thr_idle;
        logic       receiver_seen;
        rfm_event_t failsafe_event;
    } rfm_result_t;

endpackage

@@ hdl/rfm_if.sv @@
// ----------------------------------------------------------------------------
// rfm_in_if / rfm_out_if - poll and result channels
// Valid/ready channels carrying one radio poll word and one result word.
// ----------------------------------------------------------------------------
interface rfm_in_if;
    logic               valid;
    logic               ready;
    logic [31:0]        now_ms;
    logic               frame_present;
    logic [11:0]        thr_pulse;
    logic signed [15:0] throttle_ctrl;
    logic               overrides_active;
    logic               motors_armed;

    modport source (
        output valid, now_ms, frame_present, thr_pulse, throttle_ctrl,
               overrides_active, motors_armed,
        input  ready
    );
    modport sink (
        input  valid, now_ms, frame_present, thr_pulse, throttle_ctrl,
               overrides_active, motors_armed,
        output ready
    );
endinterface

interface rfm_out_if;
    logic       valid;
    logic       ready;
    logic       radio_failsafe;
    logic       thr_idle;
    logic       receiver_seen;
    logic [1:0] failsafe_event;

    modport source (
        output valid, radio_failsafe, thr_idle, receiver_seen, failsafe_event,
        input  ready
    );
    modport sink (
        input  valid, radio_failsafe, thr_idle, receiver_seen, failsafe_event,
        output ready
    );
endinterface

@@ hdl/rc_radio_failsafe_monitor.sv @@
// An accepted word waits in the input register; its result word is registered in the result register.
// Throughput: one poll word per cycle while results are taken; with a result
// word waiting, the input register holds one more word and then stalls.
// Reset (rst_n low, asynchronous): both channels empty, monitor state cleared,
// throttle-zero flag set, configuration back to its reset values.
// ----------------------------------------------------------------------------
// rc_radio_failsafe_monitor - radio failsafe monitor top level
// Input register, failsafe decision logic, result register and config bank.
// ----------------------------------------------------------------------------
module rc_radio_failsafe_monitor (
    input  logic                             clk,
    input  logic                             rst_n,
    rfm_in_if.sink                           in_ch,
    rfm_out_if.source                        out_ch,
    input  logic                             cfg_we,
    input  logic [rfm_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [rfm_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
    import rfm_pkg::*;

    rfm_cfg_t    cfg_reg;
    rfm_state_t  state_reg;
    rfm_state_t  state_next;
    rfm_item_t   in_word_reg;
    logic        in_vld_reg;
    rfm_result_t out_word_reg;
    rfm_result_t result;
    logic        out_vld_reg;
    logic        accept;
    logic        move;

    assign move         = in_vld_reg && (!out_vld_reg || out_ch.ready);
    assign in_ch.ready  = !in_vld_reg || move;
    assign accept       = in_ch.valid && in_ch.ready;

    rfm_core u_core (
        .cfg        (cfg_reg),
        .state      (state_reg),
        .item       (in_word_reg),
        .state_next (state_next),
        .result     (result)
    );

    // config bank
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.fs_enable   <= RST_FS_ENABLE;
            cfg_reg.low_pwm     <= RST_LOW_PWM;
            cfg_reg.radio_to    <= RST_RADIO_TO;
            cfg_reg.override_to <= RST_OVERRIDE_TO;
            cfg_reg.zero_db     <= RST_ZERO_DB;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_FS_ENABLE:   cfg_reg.fs_enable   <= cfg_wdata[0];
                CFG_LOW_PWM:     cfg_reg.low_pwm     <= cfg_wdata[11:0];
                CFG_RADIO_TO:    cfg_reg.radio_to    <= cfg_wdata;
                CFG_OVERRIDE_TO: cfg_reg.override_to <= cfg_wdata;
                CFG_ZERO_DB:     cfg_reg.zero_db     <= cfg_wdata;
                default:         ;
            endcase
        end
    end

    // control and monitor state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg                <= 1'b0;
            out_vld_reg               <= 1'b0;
            state_reg.failsafe        <= 1'b0;
            state_reg.low_count       <= 2'd0;
            state_reg.receiver        <= 1'b0;
            state_reg.last_frame_ms   <= 32'd0;
            state_reg.last_nonzero_ms <= 32'd0;
            state_reg.zero            <= 1'b1;
        end
        else
        begin
            if (accept)
                in_vld_reg <= 1'b1;
            else if (move)
                in_vld_reg <= 1'b0;

            if (move)
                out_vld_reg <= 1'b1;
            else if (out_ch.ready)
                out_vld_reg <= 1'b0;

            if (move)
                state_reg <= state_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_word_reg.now_ms           <= in_ch.now_ms;
            in_word_reg.frame_present    <= in_ch.frame_present;
            in_word_reg.thr_pulse        <= in_ch.thr_pulse;
            in_word_reg.throttle_ctrl    <= in_ch.throttle_ctrl;
            in_word_reg.overrides_active <= in_ch.overrides_active;
            in_word_reg.motors_armed     <= in_ch.motors_armed;
        end
        if (move)
            out_word_reg <= result;
    end

    assign out_ch.valid          = out_vld_reg;
    assign out_ch.radio_failsafe = out_word_reg.radio_failsafe;
    assign out_ch.thr_idle       = out_word_reg.thr_idle;
    assign out_ch.receiver_seen  = out_word_reg.receiver_seen;
    assign out_ch.failsafe_event = out_word_reg.failsafe_event;

    // state only changes when a word moves to the result register
    a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !move |=> $stable(state_reg))
        else $error("monitor state changed without a word moving");

    a_enter_sets_fs: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg && (out_word_reg.failsafe_event == EV_LOW_THR ||
                        out_word_reg.failsafe_event == EV_TIMEOUT)
        |-> out_word_reg.radio_failsafe)
        else $error("failsafe entry reported without failsafe active");

    a_clear_drops_fs: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg && out_word_reg.failsafe_event == EV_CLEARED
        |-> !out_word_reg.radio_failsafe && state_reg.low_count == 2'd0)
        else $error("failsafe clear reported with failsafe still active");

    a_no_rx_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg && !out_word_reg.receiver_seen
        |-> out_word_reg.thr_idle && out_word_reg.failsafe_event != EV_CLEARED)
        else $error("frame-driven result seen before any frame");

    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ch.ready |-> in_vld_reg && out_vld_reg && !out_ch.ready)
        else $error("input stalled with room in the pipeline");

endmodule

@@ hdl/rfm_core.sv @@
// ----------------------------------------------------------------------------
// rfm_core - failsafe decision logic
// Next state and result word for one poll, from current state and config.
// ----------------------------------------------------------------------------
module rfm_core (
    input  rfm_pkg::rfm_cfg_t    cfg,
    input  rfm_pkg::rfm_state_t  state,
    input  rfm_pkg::rfm_item_t   item,
    output rfm_pkg::rfm_state_t  state_next,
    output rfm_pkg::rfm_result_t result
);
    import rfm_pkg::*;

    logic        rx_or_armed;
    logic        thr_positive;
    logic [31:0] since_nonzero;
    logic [31:0] since_frame;
    logic [15:0] limit;
    logic [1:0]  cnt_up;
    logic [1:0]  cnt_down;
    rfm_event_t  event_code;

    assign rx_or_armed   = state.receiver || item.motors_armed;
    assign thr_positive  = (item.throttle_ctrl != 16'sd0) && !item.throttle_ctrl[15];
    assign since_nonzero = item.now_ms - state.last_nonzero_ms;
    assign since_frame   = item.now_ms - state.last_frame_ms;
    assign limit         = item.overrides_active ? cfg.override_to : cfg.radio_to;
    assign cnt_up        = (state.low_count < LOW_COUNT_MAX) ? state.low_count + 2'd1
                                                             : state.low_count;
    assign cnt_down      = (state.low_count != 2'd0) ? state.low_count - 2'd1 : 2'd0;

    always_comb
    begin
        state_next = state;
        event_code = EV_NONE;
        if (item.frame_present)
        begin
            if (cfg.fs_enable)
            begin
                if (item.thr_pulse < cfg.low_pwm)
                begin
                    if (!state.failsafe && rx_or_armed)
                    begin
                        state_next.low_count = cnt_up;
                        if (cnt_up == LOW_COUNT_MAX)
                        begin
                            state_next.failsafe = 1'b1;
                            event_code          = EV_LOW_THR;
                        end
                    end
                end
                else
                begin
                    state_next.low_count = cnt_down;
                    if (cnt_down == 2'd0 && state.failsafe)
                    begin
                        state_next.failsafe = 1'b0;
                        event_code          = EV_CLEARED;
                    end
                end
            end
            if (thr_positive)
            begin
                state_next.last_nonzero_ms = item.now_ms;
                state_next.zero            = 1'b0;
            end
            else if (since_nonzero > {16'd0, cfg.zero_db})
            begin
                state_next.zero = 1'b1;
            end
            state_next.receiver      = 1'b1;
            state_next.last_frame_ms = item.now_ms;
        end
        else if (!state.failsafe)
        begin
            if (since_frame >= {16'd0, limit} && cfg.fs_enable && rx_or_armed)
            begin
                state_next.failsafe = 1'b1;
                event_code          = EV_TIMEOUT;
            end
        end
    end

    assign result.radio_failsafe = state_next.failsafe;
    assign result.thr_idle       = state_next.zero;
    assign result.receiver_seen  = state_next.receiver;
    assign result.failsafe_event = event_code;

endmodule
